// File: rtl/threshold_topk_dedupe_select_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the top-k selection block.
// ---------------------------------------------------------------------------
`ifndef THRESHOLD_TOPK_DEDUPE_SELECT_MACROS_SVH
`define THRESHOLD_TOPK_DEDUPE_SELECT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define TKDS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TKDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/tkds_pkg.sv
// ---------------------------------------------------------------------------
// tkds_pkg
// Types and constants shared by the top-k selection block.
// ---------------------------------------------------------------------------
package tkds_pkg;

  localparam int MAX_KEEP_DEF = 16;
  localparam int RESULT_CAP   = 16;
  localparam int FIFO_DEPTH   = 4;

  localparam int SCORE_W   = 16;
  localparam int ID_W      = 16;
  localparam int TOPK_W    = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic signed [SCORE_W-1:0] THR_RESET  = 16'sd64;
  localparam logic [TOPK_W-1:0]         TOPK_RESET = 5'd5;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_TOP_K     = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                       keep;
    logic                       last;
    logic signed [SCORE_W-1:0]  score;
    logic [ID_W-1:0]            parent;
    logic [ID_W-1:0]            index;
  } cand_t;

endpackage

// File: rtl/tkds_front.sv
// ---------------------------------------------------------------------------
// tkds_front
// Accepts candidates, unpacks them and marks those that pass the filter.
// ---------------------------------------------------------------------------
module tkds_front (
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [47:0]                         s_tdata,
  input  logic                                s_tuser,
  input  logic                                s_tlast,
  input  logic signed [tkds_pkg::SCORE_W-1:0] threshold,
  input  logic                                q_full,
  output logic                                q_push,
  output tkds_pkg::cand_t                     q_data
);
  import tkds_pkg::*;

  logic signed [SCORE_W-1:0] score;

  assign score    = $signed(s_tdata[15:0]);
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  always_comb begin
    q_data.keep   = s_tuser && (score >= threshold);
    q_data.last   = s_tlast;
    q_data.score  = score;
    q_data.parent = s_tdata[31:16];
    q_data.index  = s_tdata[47:32];
  end

endmodule

// File: rtl/tkds_fifo.sv
// ---------------------------------------------------------------------------
// tkds_fifo
// Short candidate queue between the front and the insertion row.
// ---------------------------------------------------------------------------
module tkds_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tkds_pkg::cand_t push_data,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output tkds_pkg::cand_t pop_data
);
  import tkds_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  cand_t         mem [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full      = (count == CW'(FIFO_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CW'(push) - CW'(pop);
    end
  end

endmodule

// File: rtl/tkds_row.sv
// ---------------------------------------------------------------------------
// tkds_row
// Compare-and-shift slot row with parent deduplication and result output.
// ---------------------------------------------------------------------------
`include "threshold_topk_dedupe_select_macros.svh"

module tkds_row #(
  parameter int MAX_KEEP = tkds_pkg::MAX_KEEP_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [tkds_pkg::TOPK_W-1:0]      top_k,
  input  logic                             q_valid,
  input  tkds_pkg::cand_t                  q_data,
  output logic                             q_pop,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [47:0]                      m_tdata,
  output logic                             m_tuser,
  output logic                             m_tlast
);
  import tkds_pkg::*;

  typedef enum logic [1:0] {
    ST_RUN  = 2'b01,
    ST_EMIT = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic signed [SCORE_W-1:0] slot_score  [MAX_KEEP];
  logic [ID_W-1:0]           slot_parent [MAX_KEEP];
  logic [ID_W-1:0]           slot_index  [MAX_KEEP];
  logic [MAX_KEEP-1:0]       slot_used;

  logic [MAX_KEEP-1:0] ge;
  logic [MAX_KEEP-1:0] mt;
  logic [MAX_KEEP-1:0] ins;
  logic [MAX_KEEP-1:0] shift;
  logic                drop;
  logic                do_ins;
  logic                fire;
  logic                empty_run;
  logic                last_out;
  logic                second_used;
  logic                clear_all;
  logic                shift_out;
  logic [TOPK_W-1:0]   rem;
  logic [TOPK_W-1:0]   cap;
  logic                first;
  logic                last_pop;
  logic                used_gap;

  always_comb begin
    for (int i = 0; i < MAX_KEEP; i++) begin
      ge[i] = slot_used[i] && (slot_score[i] >= q_data.score);
      mt[i] = slot_used[i] && (slot_parent[i] == q_data.parent);
    end
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (i == 0) begin
        ins[i]   = !ge[i];
        shift[i] = 1'b0;
      end else begin
        ins[i]   = !ge[i] && ge[i-1];
        shift[i] = !ge[i-1] && ((mt & ((MAX_KEEP'(1) << i) - 1'b1)) == '0);
      end
    end
  end

  assign drop        = |(mt & ge);
  assign q_pop       = (state == ST_RUN) && q_valid;
  assign last_pop    = q_pop && q_data.last;
  assign do_ins      = q_pop && q_data.keep && !drop;
  assign fire        = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign second_used = (MAX_KEEP > 1) ? slot_used[(MAX_KEEP > 1) ? 1 : 0] : 1'b0;
  assign empty_run   = first && ((rem == '0) || !slot_used[0]);
  assign last_out    = empty_run || !second_used || (rem == TOPK_W'(1));
  assign clear_all   = fire && last_out;
  assign shift_out   = fire && !last_out;
  assign cap         = (top_k > TOPK_W'(RESULT_CAP)) ? TOPK_W'(RESULT_CAP) : top_k;
  assign used_gap    = |((slot_used >> 1) & ~slot_used);

  for (genvar g = 0; g < MAX_KEEP; g++) begin : g_cell
    logic signed [SCORE_W-1:0] prv_score;
    logic [ID_W-1:0]           prv_parent;
    logic [ID_W-1:0]           prv_index;
    logic                      prv_used;
    logic signed [SCORE_W-1:0] nxt_score;
    logic [ID_W-1:0]           nxt_parent;
    logic [ID_W-1:0]           nxt_index;
    logic                      nxt_used;

    if (g > 0) begin : g_prv
      assign prv_score  = slot_score[g-1];
      assign prv_parent = slot_parent[g-1];
      assign prv_index  = slot_index[g-1];
      assign prv_used   = slot_used[g-1];
    end else begin : g_prv0
      assign prv_score  = '0;
      assign prv_parent = '0;
      assign prv_index  = '0;
      assign prv_used   = 1'b0;
    end

    if (g < MAX_KEEP - 1) begin : g_nxt
      assign nxt_score  = slot_score[g+1];
      assign nxt_parent = slot_parent[g+1];
      assign nxt_index  = slot_index[g+1];
      assign nxt_used   = slot_used[g+1];
    end else begin : g_nxt0
      assign nxt_score  = '0;
      assign nxt_parent = '0;
      assign nxt_index  = '0;
      assign nxt_used   = 1'b0;
    end

    always_ff @(posedge clk) begin
      if (do_ins && ins[g]) begin
        slot_score[g]  <= q_data.score;
        slot_parent[g] <= q_data.parent;
        slot_index[g]  <= q_data.index;
      end else if (do_ins && shift[g]) begin
        slot_score[g]  <= prv_score;
        slot_parent[g] <= prv_parent;
        slot_index[g]  <= prv_index;
      end else if (shift_out) begin
        slot_score[g]  <= nxt_score;
        slot_parent[g] <= nxt_parent;
        slot_index[g]  <= nxt_index;
      end
    end

    always_ff @(posedge clk) begin
      if (rst || clear_all) begin
        slot_used[g] <= 1'b0;
      end else if (do_ins && ins[g]) begin
        slot_used[g] <= 1'b1;
      end else if (do_ins && shift[g]) begin
        slot_used[g] <= prv_used;
      end else if (shift_out) begin
        slot_used[g] <= nxt_used;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_RUN: begin
        if (last_pop) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (clear_all) begin
          state_next = ST_RUN;
        end
      end
      default: state_next = ST_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_RUN;
      m_tvalid <= 1'b0;
      rem      <= '0;
      first    <= 1'b0;
    end else begin
      state <= state_next;
      if (last_pop) begin
        rem   <= cap;
        first <= 1'b1;
      end else if (shift_out) begin
        rem   <= rem - 1'b1;
        first <= 1'b0;
      end
      if (fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tuser <= !empty_run;
      m_tlast <= last_out;
      if (empty_run) begin
        m_tdata <= '0;
      end else begin
        m_tdata <= {slot_score[0], slot_parent[0], slot_index[0]};
      end
    end
  end

  `TKDS_ASSERT_IMPL(a_used_packed, clk, rst, 1'b1, !used_gap, "slot row not packed")
  `TKDS_ASSERT_IMPL(a_no_pop_emit, clk, rst, state == ST_EMIT, !q_pop, "popped while emitting")
  `TKDS_ASSERT_NEXT(a_last_to_emit, clk, rst, last_pop, state == ST_EMIT, "emission not started")
  `TKDS_ASSERT_NEXT(a_clear_after, clk, rst, clear_all, slot_used == '0, "slots not cleared")
  `TKDS_ASSERT_NEXT(a_close_out, clk, rst, clear_all, m_tvalid && m_tlast, "run not closed")

endmodule

// File: rtl/threshold_topk_dedupe_select.sv
// ---------------------------------------------------------------------------
// threshold_topk_dedupe_select
// Threshold filter with top-k selection, one candidate kept per parent.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  s_*      in   tvalid/tready      tdata score,parent,index; tuser score_ok; tlast
//  m_*      out  tvalid/tready      tdata index,parent,score; tuser hit_valid; tlast
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
// Each candidate is inserted into the slot row as it is popped, so one item
// per cycle is sustained while a run is being collected. After the last item
// the row emits one result per cycle while m_tready allows, up to top_k or one
// empty marker; the queue is not drained meanwhile and its four entries
// absorb input until full. Synchronous reset clears slot valid bits, queue and output.
module threshold_topk_dedupe_select #(
  parameter int MAX_KEEP = tkds_pkg::MAX_KEEP_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [47:0]                        s_tdata,   // score, parent_id, chunk_index
  input  logic                               s_tuser,   // score_ok
  input  logic                               s_tlast,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [47:0]                        m_tdata,   // hit_index, hit_parent, hit_score
  output logic                               m_tuser,   // hit_valid
  output logic                               m_tlast,
  input  logic                               cfg_we,
  input  logic [tkds_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tkds_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import tkds_pkg::*;

  logic signed [SCORE_W-1:0] threshold;
  logic [TOPK_W-1:0]         top_k;
  logic                      q_full;
  logic                      q_push;
  cand_t                     q_in;
  logic                      q_pop;
  logic                      q_valid;
  cand_t                     q_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
      top_k     <= TOPK_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_THRESHOLD: threshold <= $signed(cfg_data[SCORE_W-1:0]);
        CFG_TOP_K:     top_k     <= cfg_data[TOPK_W-1:0];
        default: ;
      endcase
    end
  end

  tkds_front u_front (
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .threshold (threshold),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  tkds_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_data  (q_out)
  );

  tkds_row #(
    .MAX_KEEP (MAX_KEEP)
  ) u_row (
    .clk      (clk),
    .rst      (rst),
    .top_k    (top_k),
    .q_valid  (q_valid),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: dv/tb_threshold_topk_dedupe_select.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Top-k selection testbench
// Streams scored candidates into the block and checks every emitted hit
// against a ranked list kept in the bench. The list drops failed and
// under-threshold candidates and keeps one entry per parent. Directed runs
// cover the threshold boundary, ties, parent replacement, a full list and
// an empty run. Random phases change the threshold, top_k and the idling on
// both stream sides.
// ---------------------------------------------------------------------------
module tb_threshold_topk_dedupe_select;
  import tkds_pkg::*;

  localparam int KEEP_SLOTS    = MAX_KEEP_DEF;
  localparam int SETTLE_CYCLES = 64;
  localparam int PHASE_ITEMS   = 45;

  typedef struct {
    logic signed [15:0] score;
    logic               ok;
    logic [15:0]        parent;
    logic [15:0]        index;
    logic               last;
  } cand_item_t;

  typedef struct {
    logic signed [15:0] score;
    logic [15:0]        parent;
    logic [15:0]        index;
  } slot_t;

  typedef struct {
    logic               valid;
    logic [15:0]        index;
    logic [15:0]        parent;
    logic signed [15:0] score;
    logic               eol;
  } hit_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;  // score, parent_id, chunk_index
  logic        s_tuser = 1'b0;  // score_ok
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // hit_index, hit_parent, hit_score
  logic        m_tuser;  // hit_valid
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cand_item_t cand_feed[$];
  cand_item_t in_flight;
  slot_t      ranked[$];
  hit_t       pending_hits[$];
  int         cands_outstanding = 0;
  int         error_count = 0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;

  logic signed [15:0] thr_model = THR_RESET;
  logic [4:0]         topk_model = TOPK_RESET;

  threshold_topk_dedupe_select DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  task automatic flag_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  // Ranks one accepted candidate and, on the last item, emits the list.
  function automatic void take_candidate(cand_item_t c);
    slot_t e;
    hit_t  h;
    int    pos;
    int    n;
    bit    keep;
    keep = c.ok && (c.score >= thr_model);
    for (int i = 0; keep && i < ranked.size(); i++) begin
      if (ranked[i].parent == c.parent) begin
        if (c.score <= ranked[i].score) keep = 1'b0;
        else ranked.delete(i);
        break;
      end
    end
    if (keep) begin
      pos = 0;
      while (pos < ranked.size() && ranked[pos].score >= c.score) pos++;
      if (pos < KEEP_SLOTS) begin
        if (ranked.size() == KEEP_SLOTS) void'(ranked.pop_back());
        e.score = c.score;
        e.parent = c.parent;
        e.index = c.index;
        ranked.insert(pos, e);
      end
    end
    if (c.last) begin
      n = ranked.size();
      if (n > int'(topk_model)) n = int'(topk_model);
      if (n > RESULT_CAP) n = RESULT_CAP;
      if (n == 0) begin
        h = '{1'b0, 16'd0, 16'd0, 16'sd0, 1'b1};
        pending_hits.insert(pending_hits.size(), h);
      end
      for (int k = 0; k < n; k++) begin
        h = '{1'b1, ranked[k].index, ranked[k].parent, ranked[k].score, k == n - 1};
        pending_hits.insert(pending_hits.size(), h);
      end
      ranked.delete();
    end
  endfunction

  always @(posedge clk) begin : drive_proc
    cand_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        take_candidate(in_flight);
        cands_outstanding--;
      end
      if (!s_tvalid || s_tready) begin
        if (cand_feed.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = cand_feed.pop_front();
          in_flight = nxt;
          s_tvalid <= 1'b1;
          s_tdata <= {nxt.index, nxt.parent, nxt.score};
          s_tuser <= nxt.ok;
          s_tlast <= nxt.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_proc
    hit_t exp_h;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_hits.size() == 0) begin
        flag_error($sformatf("unexpected result transfer idx=%h par=%h", m_tdata[15:0],
                             m_tdata[31:16]));
      end else begin
        exp_h = pending_hits.pop_front();
        if (m_tuser !== exp_h.valid || m_tdata[15:0] !== exp_h.index ||
            m_tdata[31:16] !== exp_h.parent || m_tdata[47:32] !== exp_h.score ||
            m_tlast !== exp_h.eol)
          flag_error($sformatf(
            "got v=%b idx=%h par=%h sc=%0d eol=%b, exp v=%b idx=%h par=%h sc=%0d eol=%b",
            m_tuser, m_tdata[15:0], m_tdata[31:16], $signed(m_tdata[47:32]), m_tlast,
            exp_h.valid, exp_h.index, exp_h.parent, exp_h.score, exp_h.eol));
      end
    end
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  task automatic push_item(int score, bit ok, int parent, int index, bit last);
    cand_item_t c;
    c.score = 16'(score);
    c.ok = ok;
    c.parent = 16'(parent);
    c.index = 16'(index);
    c.last = last;
    cands_outstanding++;
    cand_feed.insert(cand_feed.size(), c);
  endtask

  task automatic wait_quiet();
    while (cands_outstanding != 0 || pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (r == CFG_THRESHOLD) thr_model = v;
    else topk_model = v[4:0];
  endtask

  // One run of candidates drawn from a small set of parents, so that
  // replacement and ties happen often.
  task automatic queue_run(int len, bit noisy, bit mid_write);
    logic [15:0] pool[24];
    int npool;
    int pick;
    int s;
    npool = $urandom_range(24, 1);
    for (int i = 0; i < npool; i++)
      pool[i] = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(30));
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(99);
      if (noisy || pick < 35) s = int'($signed(16'($urandom)));
      else if (pick < 80) s = int'(thr_model) + int'($urandom_range(16)) - 4;
      else s = $urandom_range(1) ? 32767 : int'(thr_model);
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      push_item(s, noisy ? 1'($urandom_range(1)) : ($urandom_range(19) != 0),
                pool[$urandom_range(npool - 1)], $urandom, i == len - 1);
      if (mid_write && i == len / 2) begin
        wait_quiet();
        write_reg(CFG_THRESHOLD, 16'($urandom_range(600)) - 16'd200);
      end
    end
  endtask

  initial begin : stim_proc
    int thr_set[8];
    int topk_set[8];
    int issued;
    int len;
    int pick;
    thr_set = '{64, -32768, 32767, 0, 0, -256, 256, 0};
    topk_set = '{16, 0, 16, 1, 0, 16, 3, 0};
    thr_set[4] = int'($signed(16'($urandom)));
    thr_set[7] = int'($urandom_range(400)) - 100;
    topk_set[4] = $urandom_range(16);
    topk_set[7] = $urandom_range(16);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: threshold boundary, failed score, ties, replacement.
    push_item(64, 1, 1, 'h0000, 0);
    push_item(63, 1, 4, 'h0011, 0);
    push_item(32767, 0, 5, 'h0022, 0);
    push_item(32767, 1, 2, 'hFFFF, 0);
    push_item(32767, 1, 3, 'h0033, 0);
    push_item(100, 1, 1, 'h0044, 0);
    push_item(32767, 1, 2, 'h0055, 1);
    // Empty run whose last item is itself dropped.
    push_item(-32768, 1, 'hFFFF, 'h0066, 1);
    wait_quiet();

    // Full list: a tie with the lowest slot is dropped, a better one
    // pushes the lowest slot off the end.
    write_reg(CFG_THRESHOLD, 16'h8000);
    write_reg(CFG_TOP_K, 5'd16);
    for (int i = 0; i < 15; i++) push_item(16000 - 1000 * i, 1, 100 + i, 'h100 + i, 0);
    push_item(-32768, 1, 115, 'h10F, 0);
    push_item(-32768, 1, 116, 'h110, 0);
    push_item(32767, 1, 117, 'h111, 1);
    wait_quiet();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_THRESHOLD, 16'(thr_set[ph]));
      write_reg(CFG_TOP_K, 16'(topk_set[ph]));
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 73; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 73; end
        default: begin send_idle_pct = 19; stall_pct = 19; end
      endcase
      issued = 0;
      while (issued < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(12, 1);
        else if (pick < 95) len = $urandom_range(30, 13);
        else len = $urandom_range(45, 31);
        if (ph == 5 && issued == 0) len = $urandom_range(20, 10);
        queue_run(len, $urandom_range(9) == 0, ph == 5 && issued == 0);
        issued += len;
      end
      wait_quiet();
    end

    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : limit_proc
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
